/* sv/complex_decimal_accumulator_macros.svh */
// Assertion macros used by the complex decimal accumulator top level.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef COMPLEX_DECIMAL_ACCUMULATOR_MACROS_SVH
`define COMPLEX_DECIMAL_ACCUMULATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/cda_pkg.sv */
// Shared types, constants and BCD helper functions for the complex decimal accumulator.
// Depends on nothing; used by cda_part and complex_decimal_accumulator.
package cda_pkg;

    localparam int unsigned DIGITS_DEF   = 8;
    localparam int unsigned FIELD_DIGITS = 8;
    localparam int unsigned MAG_W        = 4 * FIELD_DIGITS;

    localparam logic [3:0] BCD_MAX  = 4'd9;
    localparam logic [4:0] BCD_BASE = 5'd10;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_HOLD = 2'd3
    } t_op;

    // One signed-magnitude part of the complex value.
    typedef struct packed {
        logic             sign;
        logic [MAG_W-1:0] mag;
    } t_part;

    // Saturate every nibble to 9 and clear the digits at or above eff.
    function automatic logic [MAG_W-1:0] normalize(logic [MAG_W-1:0] v,
                                                  int unsigned eff);
        logic [MAG_W-1:0] r;
        logic [3:0]       d;
        r = '0;
        for (int i = 0; i < FIELD_DIGITS; i++) begin
            d = v[4*i +: 4];
            if (i < eff) begin
                r[4*i +: 4] = (d > BCD_MAX) ? BCD_MAX : d;
            end
        end
        return r;
    endfunction

    function automatic logic is_bcd(logic [MAG_W-1:0] v);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < FIELD_DIGITS; i++) begin
            if (v[4*i +: 4] > BCD_MAX) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

/* sv/cda_part.sv */
// Signed-magnitude decimal add for one part (real or imaginary) of the accumulator.
// Depends on cda_pkg; both magnitudes must already be normalized BCD.
module cda_part #(
    parameter int unsigned P_DIGITS = cda_pkg::DIGITS_DEF
) (
    input  cda_pkg::t_part i_acc,
    input  cda_pkg::t_part i_opd,
    output cda_pkg::t_part o_res
);

    localparam int unsigned EFF = (P_DIGITS < cda_pkg::FIELD_DIGITS) ?
                                  P_DIGITS : cda_pkg::FIELD_DIGITS;

    function automatic logic [cda_pkg::MAG_W-1:0] bcd_add(
        logic [cda_pkg::MAG_W-1:0] a, logic [cda_pkg::MAG_W-1:0] b);
        logic [cda_pkg::MAG_W-1:0] r;
        logic [4:0]                s;
        logic                      c;
        r = '0;
        c = 1'b0;
        for (int i = 0; i < cda_pkg::FIELD_DIGITS; i++) begin
            s = {1'b0, a[4*i +: 4]} + {1'b0, b[4*i +: 4]} + {4'd0, c};
            if (i < EFF) begin
                c = (s >= cda_pkg::BCD_BASE);
                if (c) begin
                    s = s - cda_pkg::BCD_BASE;
                end
                r[4*i +: 4] = s[3:0];
            end
        end
        return r;
    endfunction

    // Returns {borrow out, a - b}; the borrow out is set when a is below b.
    function automatic logic [cda_pkg::MAG_W:0] bcd_sub(
        logic [cda_pkg::MAG_W-1:0] a, logic [cda_pkg::MAG_W-1:0] b);
        logic [cda_pkg::MAG_W-1:0] r;
        logic [4:0]                sub;
        logic [4:0]                da;
        logic                      bw;
        r  = '0;
        bw = 1'b0;
        for (int i = 0; i < cda_pkg::FIELD_DIGITS; i++) begin
            da  = {1'b0, a[4*i +: 4]};
            sub = {1'b0, b[4*i +: 4]} + {4'd0, bw};
            if (i < EFF) begin
                if (da >= sub) begin
                    r[4*i +: 4] = 4'(da - sub);
                    bw          = 1'b0;
                end else begin
                    r[4*i +: 4] = 4'(da + cda_pkg::BCD_BASE - sub);
                    bw          = 1'b1;
                end
            end
        end
        return {bw, r};
    endfunction

    logic [cda_pkg::MAG_W-1:0] sum;
    logic [cda_pkg::MAG_W:0]   diff_ab;
    logic [cda_pkg::MAG_W:0]   diff_ba;

    assign sum     = bcd_add(i_acc.mag, i_opd.mag);
    assign diff_ab = bcd_sub(i_acc.mag, i_opd.mag);
    assign diff_ba = bcd_sub(i_opd.mag, i_acc.mag);

    // The borrow out of acc - opd doubles as the magnitude compare.
    always_comb begin
        if (i_acc.sign == i_opd.sign) begin
            o_res = '{sign: i_acc.sign, mag: sum};
        end else if (diff_ab[cda_pkg::MAG_W]) begin
            o_res = '{sign: i_opd.sign, mag: diff_ba[cda_pkg::MAG_W-1:0]};
        end else if (diff_ab[cda_pkg::MAG_W-1:0] == '0) begin
            o_res = '{sign: 1'b0, mag: '0};
        end else begin
            o_res = '{sign: i_acc.sign, mag: diff_ab[cda_pkg::MAG_W-1:0]};
        end
    end

endmodule

/* sv/complex_decimal_accumulator.sv */
// Complex decimal accumulator top level: request registers, accumulator and handshake.
// Depends on cda_pkg, cda_part and complex_decimal_accumulator_macros.svh.
//
//   channel  direction  handshake                   payload
//   in       request    i_in_valid / o_in_stall     i_operation, i_operand_*
//   out      result     o_out_valid / i_out_stall   o_result_*
//
// One request per cycle is sustained while the result does not stall.
// The accumulator itself is the result register, updated as a request leaves the
// input register, so back-to-back requests see each other's results.
// Synchronous active-low reset clears the accumulator to positive zero and empties both stages.
// While the result is stalled, one more request is still taken into the input register.
`include "complex_decimal_accumulator_macros.svh"

module complex_decimal_accumulator #(
    parameter int unsigned P_DIGITS = cda_pkg::DIGITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_operation,
    input  logic                      i_operand_real_sign,
    input  logic [cda_pkg::MAG_W-1:0] i_operand_real_digits,
    input  logic                      i_operand_imag_sign,
    input  logic [cda_pkg::MAG_W-1:0] i_operand_imag_digits,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_result_real_sign,
    output logic [cda_pkg::MAG_W-1:0] o_result_real_digits,
    output logic                      o_result_imag_sign,
    output logic [cda_pkg::MAG_W-1:0] o_result_imag_digits
);

    localparam int unsigned EFF = (P_DIGITS < cda_pkg::FIELD_DIGITS) ?
                                  P_DIGITS : cda_pkg::FIELD_DIGITS;

    logic           r_in_vld, n_in_vld;
    logic           r_out_vld, n_out_vld;
    cda_pkg::t_op   r_op;
    cda_pkg::t_part r_in_re, r_in_im;
    cda_pkg::t_part r_acc_re, r_acc_im;
    cda_pkg::t_part n_acc_re, n_acc_im;
    cda_pkg::t_part opd_re, opd_im;
    cda_pkg::t_part res_re, res_im;
    logic           out_take;
    logic           advance;
    logic           in_acc;
    logic           flip;
    logic           acc_bcd;

    assign out_take   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && out_take;
    assign o_in_stall = r_in_vld && !out_take;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_vld = r_in_vld;
        if (in_acc) begin
            n_in_vld = 1'b1;
        end else if (advance) begin
            n_in_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (advance) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    // Operands are normalized on capture so the adders only ever see BCD.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= cda_pkg::t_op'(i_operation);
            r_in_re <= '{sign: i_operand_real_sign,
                         mag: cda_pkg::normalize(i_operand_real_digits, EFF)};
            r_in_im <= '{sign: i_operand_imag_sign,
                         mag: cda_pkg::normalize(i_operand_imag_digits, EFF)};
        end
    end

    assign flip   = (r_op == cda_pkg::OP_SUB);
    assign opd_re = '{sign: r_in_re.sign ^ flip, mag: r_in_re.mag};
    assign opd_im = '{sign: r_in_im.sign ^ flip, mag: r_in_im.mag};

    cda_part #(.P_DIGITS(P_DIGITS)) u_part_re (
        .i_acc (r_acc_re),
        .i_opd (opd_re),
        .o_res (res_re)
    );

    cda_part #(.P_DIGITS(P_DIGITS)) u_part_im (
        .i_acc (r_acc_im),
        .i_opd (opd_im),
        .o_res (res_im)
    );

    always_comb begin
        unique case (r_op) inside
            cda_pkg::OP_LOAD: begin
                n_acc_re = r_in_re;
                n_acc_im = r_in_im;
            end
            cda_pkg::OP_ADD, cda_pkg::OP_SUB: begin
                n_acc_re = res_re;
                n_acc_im = res_im;
            end
            default: begin
                n_acc_re = r_acc_re;
                n_acc_im = r_acc_im;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc_re  <= '0;
            r_acc_im  <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (advance) begin
                r_acc_re <= n_acc_re;
                r_acc_im <= n_acc_im;
            end
        end
    end

    assign o_out_valid          = r_out_vld;
    assign o_result_real_sign   = r_acc_re.sign;
    assign o_result_real_digits = r_acc_re.mag;
    assign o_result_imag_sign   = r_acc_im.sign;
    assign o_result_imag_digits = r_acc_im.mag;

    assign acc_bcd = cda_pkg::is_bcd(r_acc_re.mag) && cda_pkg::is_bcd(r_acc_im.mag);

    `CDA_ASSERT_NOW(a_stall_needs_full, o_in_stall, r_in_vld, "input stalled while empty")
    `CDA_ASSERT_NEXT(a_accept_fills, in_acc, r_in_vld, "accepted request was not captured")
    `CDA_ASSERT_NOW(a_acc_is_bcd, 1'b1, acc_bcd, "accumulator holds a non-BCD digit")
    `CDA_ASSERT_NEXT(a_acc_holds, !advance, $stable({r_acc_re, r_acc_im}), "accumulator changed")
    `CDA_ASSERT_NEXT(a_advance_shows, advance, r_out_vld, "processed request produced no result")

endmodule
